// ===== rtl/vce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vce_pkg: shared definitions for the voxel chunk RLE encoder
// Chunk geometry, derived widths, section codes and controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package vce_pkg;

  localparam int CHUNK_EDGE  = 16;
  localparam int VOXEL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  // Deepest run list that can still win against raw storage
  localparam int RUN_DEPTH   = (VOXEL_COUNT - 1) / 3;
  localparam int HEAD_BYTES  = 5;

  localparam int VOX_AW    = $clog2(VOXEL_COUNT);
  localparam int RUN_AW    = $clog2(RUN_DEPTH);
  localparam int CNT_W     = $clog2(VOXEL_COUNT + 1);
  localparam int RUN_CNT_W = $clog2(RUN_DEPTH + 2);
  localparam int POS_W     = $clog2(VOXEL_COUNT + HEAD_BYTES);
  localparam int TOT_W     = $clog2(VOXEL_COUNT + HEAD_BYTES + 1);
  localparam int RUN_LEN_W = 16;
  localparam int RUN_W     = RUN_LEN_W + 8;

  localparam logic [RUN_LEN_W-1:0] RUN_LIMIT = 16'hFFFF;

  localparam logic       OP_LOAD  = 1'b0;
  localparam logic       OP_FETCH = 1'b1;
  localparam logic [7:0] ENC_RAW  = 8'd0;
  localparam logic [7:0] ENC_RUNS = 8'd1;

  typedef struct packed {
    logic load;   // store a voxel and track runs
    logic fetch;  // launch the memory read for the next section byte
    logic close;  // close the final open run and pick the encoding
    logic emit;   // place the selected byte in the output register
  } vce_cmd_t;

  typedef struct packed {
    logic complete;    // whole chunk loaded; close then picks the encoding
    logic final_load;  // next load is the last voxel of the chunk
    logic slot_free;   // output register free or being taken
    logic last_pos;    // pending byte is the final byte of the section
  } vce_status_t;

endpackage

// ===== rtl/vce_feed_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vce_feed_if: input channel of the voxel chunk RLE encoder
// Carries one load or fetch word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface vce_feed_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] voxel_id;

  modport source (output valid, output operation, output voxel_id, input ready);
  modport sink   (input valid, input operation, input voxel_id, output ready);
endinterface

// ===== rtl/vce_section_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vce_section_if: output channel of the voxel chunk RLE encoder
// Carries one byte of the encoded section per valid/ready handshake.
// ----------------------------------------------------------------------------
interface vce_section_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== rtl/voxel_chunk_rle_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_chunk_rle_encoder: run-length encoder with raw fallback for one chunk
// Loads CHUNK_EDGE^3 voxel ids, then streams out the encoded section.
// ----------------------------------------------------------------------------
// Timing: after the final load the sequencer spends an extra close state to
//   write the last run into the run memory, which has a single write port.
// A fetch launches the registered memory read, then loads the output register
//   once that is free; no new word is taken until the byte is emitted.
// Reset (rst, synchronous): clears counters, flags and the output valid;
//   memory contents are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
module voxel_chunk_rle_encoder
  import vce_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  vce_feed_if.sink      feed,
  vce_section_if.source section
);

  vce_cmd_t    cmd;
  vce_status_t status;

  // Sequencer: accept words, hold off input while closing or reading
  vce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .valid     (feed.valid),
    .operation (feed.operation),
    .ready     (feed.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: voxel and run memories, counters, output register
  vce_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .voxel_id (feed.voxel_id),
    .cmd      (cmd),
    .status   (status),
    .section  (section)
  );

  // A launched read blocks new words for the following cycle
  a_fetch_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> !feed.ready)
    else $error("input accepted during fetch read");

  // An emitted byte shows up on the section channel
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> section.valid)
    else $error("emitted byte not presented");

  // Closing the last run completes the chunk
  a_close_done: assert property (@(posedge clk) disable iff (rst)
    cmd.close |=> status.complete)
    else $error("chunk not complete after closing run");

  // The final byte of the section empties the block
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_pos) |=> !status.complete)
    else $error("block not emptied after final byte");

endmodule

// ===== rtl/vce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vce_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds until the
// next read.
// ----------------------------------------------------------------------------
module vce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vce_ctrl: sequencer of the voxel chunk RLE encoder
// Accepts words, issues datapath commands, closes the last run after the
// final load and waits out the memory read of a fetch.
// ----------------------------------------------------------------------------
module vce_ctrl
  import vce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        operation,
  output logic        ready,
  input  vce_status_t status,
  output vce_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLOSE,
    S_READ
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign ready  = (state == S_IDLE);
  assign accept = valid && ready;

  always_comb begin
    cmd       = '0;
    cmd.load  = accept && (operation == OP_LOAD) && !status.complete;
    cmd.fetch = accept && (operation == OP_FETCH) && status.complete;
    cmd.close = (state == S_CLOSE);
    cmd.emit  = (state == S_READ) && status.slot_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load && status.final_load) begin
          state_next = S_CLOSE;
        end else if (cmd.fetch) begin
          state_next = S_READ;
        end
      end
      S_CLOSE: state_next = S_IDLE;
      S_READ: begin
        if (status.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/vce_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vce_datapath: storage, run tracking and byte selection
// Holds the voxel and run memories, the counters of the chunk and the
// output register of the section channel.
// ----------------------------------------------------------------------------
module vce_datapath
  import vce_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       voxel_id,
  input  vce_cmd_t         cmd,
  output vce_status_t      status,
  vce_section_if.source    section
);

  logic [CNT_W-1:0]     loaded_count;
  logic [RUN_CNT_W-1:0] run_total;
  logic [RUN_LEN_W-1:0] open_run_length;
  logic [7:0]           open_run_value;
  logic [POS_W-1:0]     emit_position;
  logic                 chose_runs;
  logic [VOX_AW-1:0]    data_addr;
  logic [1:0]           sub;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 last_byte;

  logic                 extend_run;
  logic                 close_en;
  logic                 run_we;
  logic                 run_inc;
  logic [RUN_CNT_W-1:0] run_total_next;
  logic [TOT_W-1:0]     runs_x3_next;
  logic [TOT_W-1:0]     payload;
  logic [TOT_W-1:0]     total;
  logic [31:0]          payload_word;
  logic [7:0]           vox_rdata;
  logic [RUN_W-1:0]     run_rdata;
  logic [7:0]           sel_byte;
  logic                 last_pos;

  // Run tracking
  assign extend_run = (voxel_id == open_run_value) && (open_run_length < RUN_LIMIT);
  assign close_en   = (cmd.load && (loaded_count != '0) && !extend_run) || cmd.close;
  assign run_we     = close_en && (run_total < RUN_CNT_W'(RUN_DEPTH));
  assign run_inc    = run_total <= RUN_CNT_W'(RUN_DEPTH);
  assign run_total_next = run_total + RUN_CNT_W'(run_inc);
  assign runs_x3_next   = TOT_W'(run_total_next) + TOT_W'({run_total_next, 1'b0});

  vce_ram #(.WIDTH(8), .DEPTH(VOXEL_COUNT)) u_voxel_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (loaded_count[VOX_AW-1:0]),
    .wdata (voxel_id),
    .re    (cmd.fetch),
    .raddr (data_addr),
    .rdata (vox_rdata)
  );

  vce_ram #(.WIDTH(RUN_W), .DEPTH(RUN_DEPTH)) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_total[RUN_AW-1:0]),
    .wdata ({open_run_value, open_run_length}),
    .re    (cmd.fetch),
    .raddr (data_addr[RUN_AW-1:0]),
    .rdata (run_rdata)
  );

  // Section byte selection
  assign payload = chose_runs ? (TOT_W'(run_total) + TOT_W'({run_total, 1'b0}))
                              : TOT_W'(VOXEL_COUNT);
  assign total        = payload + TOT_W'(HEAD_BYTES);
  assign payload_word = 32'(payload);
  assign last_pos     = (TOT_W'(emit_position) + TOT_W'(1)) >= total;

  always_comb begin
    sel_byte = vox_rdata;
    if (emit_position < POS_W'(HEAD_BYTES)) begin
      case (emit_position[2:0])
        3'd0:    sel_byte = chose_runs ? ENC_RUNS : ENC_RAW;
        3'd1:    sel_byte = payload_word[7:0];
        3'd2:    sel_byte = payload_word[15:8];
        3'd3:    sel_byte = payload_word[23:16];
        default: sel_byte = payload_word[31:24];
      endcase
    end else if (chose_runs) begin
      case (sub)
        2'd0:    sel_byte = run_rdata[7:0];
        2'd1:    sel_byte = run_rdata[15:8];
        default: sel_byte = run_rdata[23:16];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count    <= '0;
      run_total       <= '0;
      open_run_length <= '0;
      open_run_value  <= '0;
      emit_position   <= '0;
      chose_runs      <= 1'b0;
      data_addr       <= '0;
      sub             <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.load) begin
        loaded_count <= loaded_count + CNT_W'(1);
        if (extend_run && (loaded_count != '0)) begin
          open_run_length <= open_run_length + RUN_LEN_W'(1);
        end else begin
          open_run_value  <= voxel_id;
          open_run_length <= RUN_LEN_W'(1);
        end
      end
      if (close_en) begin
        run_total <= run_total_next;
      end
      if (cmd.close) begin
        chose_runs <= runs_x3_next < TOT_W'(VOXEL_COUNT);
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (section.valid && section.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        if (last_pos) begin
          loaded_count    <= '0;
          run_total       <= '0;
          open_run_length <= '0;
          open_run_value  <= '0;
          emit_position   <= '0;
          chose_runs      <= 1'b0;
          data_addr       <= '0;
          sub             <= '0;
        end else begin
          emit_position <= emit_position + POS_W'(1);
          if (emit_position >= POS_W'(HEAD_BYTES)) begin
            if (!chose_runs || (sub == 2'd2)) begin
              sub       <= '0;
              data_addr <= data_addr + VOX_AW'(1);
            end else begin
              sub <= sub + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte  <= sel_byte;
      last_byte <= last_pos;
    end
  end

  assign section.valid     = out_valid;
  assign section.out_byte  = out_byte;
  assign section.last_byte = last_byte;

  assign status.complete   = loaded_count == CNT_W'(VOXEL_COUNT);
  assign status.final_load = loaded_count == CNT_W'(VOXEL_COUNT - 1);
  assign status.slot_free  = !out_valid || section.ready;
  assign status.last_pos   = last_pos;

endmodule
